### sv/cbmi_pkg.sv
// Package for the cartridge bank mapper: codes, widths and address map constants.
`default_nettype none
package cbmi_pkg;

  // Work RAM geometry
  localparam int WORK_RAM_DEPTH = 8192;
  localparam int RAM_AW         = $clog2(WORK_RAM_DEPTH);

  // Field widths
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int TGT_W    = 2;
  localparam int OFFS_W   = 21;
  localparam int COUNT_W  = 9;
  localparam int CFG_IDX_W = 1;

  // Packed stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Transaction kinds
  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Result targets
  typedef enum logic [TGT_W-1:0] {
    TGT_NONE = 2'd0,
    TGT_CHR  = 2'd1,
    TGT_PRG  = 2'd2,
    TGT_RAM  = 2'd3
  } tgt_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_BANK_COUNT = 1'b1;

  // Register reset values
  localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 9'd2;
  localparam logic [COUNT_W-1:0] CHR_COUNT_RESET = 9'd0;

  // Address regions selected by address bits 15:13
  localparam logic [2:0] REGION_CHR = 3'b000;
  localparam logic [2:0] REGION_RAM = 3'b011;

  // Register groups selected by address bits 14:13 in the upper half
  localparam logic [1:0] GRP_BANK   = 2'd0;
  localparam logic [1:0] GRP_MIRROR = 2'd1;
  localparam logic [1:0] GRP_LATCH  = 2'd2;
  localparam logic [1:0] GRP_IRQ_EN = 2'd3;

  // Program windows selected by address bits 14:13
  localparam logic [1:0] WIN_0 = 2'd0;
  localparam logic [1:0] WIN_1 = 2'd1;
  localparam logic [1:0] WIN_2 = 2'd2;
  localparam logic [1:0] WIN_3 = 2'd3;

  // Bank table slots with fixed roles
  localparam logic [2:0] SLOT_PRG_A = 3'd6;
  localparam logic [2:0] SLOT_PRG_B = 3'd7;
  localparam logic [2:0] SLOT_CHR_1K = 3'd2;

endpackage
`default_nettype wire

### sv/cartridge_bank_mapper_irq_unit.sv
// Cartridge bank mapper with scanline IRQ counter: top level.
//
// Usage: each input transaction is a read, a write or a scanline tick
// (in_tuser holds the kind, in_tdata the address and write byte). Every
// transaction yields exactly one result transaction: the target space in
// out_tuser, and in out_tdata the translated ROM offset, its range flag,
// the work RAM read byte, the IRQ flag and the mirroring bit.
// Each transaction passes one input register (the work RAM read port is
// clocked there too) and one result register. Throughput is one
// transaction per cycle while the receiver does not stall and no clearing
// sweep runs; the work RAM read port is used once per transaction and the
// write port once per write.
// A stalled receiver holds the result register; one further transaction
// may sit in the input register, after which in_tready drops.
// Reset (synchronous, active low) restores all mapper state and then
// zeroes the 8192-byte work RAM, one byte per cycle; in_tready stays low
// until the sweep is done. Configuration writes are taken
// at any time, including during that sweep.
`default_nettype none
module cartridge_bank_mapper_irq_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [cbmi_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] address, [23:16] write_data
  input  wire logic [cbmi_pkg::OP_W-1:0]          in_tuser,   // [1:0] opcode
  // Result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [cbmi_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [20:0] rom_offset,
                                                              // [21] offset_in_range,
                                                              // [29:22] read_data,
                                                              // [30] irq_pending,
                                                              // [31] mirror_vertical
  output logic [cbmi_pkg::TGT_W-1:0]              out_tuser,  // [1:0] target
  // Configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [cbmi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cbmi_pkg::COUNT_W-1:0]       cfg_data
);
  import cbmi_pkg::*;

  // Configuration registers
  logic [COUNT_W-1:0] prg_count_r;
  logic [COUNT_W-1:0] chr_count_r;

  // Work RAM and its clearing sweep
  logic [BYTE_W-1:0] work_ram [WORK_RAM_DEPTH];
  logic              clr_busy_r;
  logic [RAM_AW-1:0] clr_addr_r;
  logic [BYTE_W-1:0] ram_rd_r;
  logic              fwd_hit_r;
  logic [BYTE_W-1:0] fwd_data_r;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              item_ram_we;

  // Input register
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [BYTE_W-1:0] s1_data_r;

  // Mapper state
  logic [2:0]        bank_index_r,    bank_index_nxt;
  logic              prg_swap_r,      prg_swap_nxt;
  logic              chr_invert_r,    chr_invert_nxt;
  logic [BYTE_W-1:0] bank_table_r [8];
  logic              bank_we;
  logic              ram_enabled_r,   ram_enabled_nxt;
  logic              ram_protected_r, ram_protected_nxt;
  logic              mirror_vert_r,   mirror_vert_nxt;
  logic [BYTE_W-1:0] irq_latch_r,     irq_latch_nxt;
  logic [BYTE_W-1:0] irq_count_r,     irq_count_nxt;
  logic              irq_reload_r,    irq_reload_nxt;
  logic              irq_enable_r,    irq_enable_nxt;
  logic              irq_flag_r,      irq_flag_nxt;

  // Result register
  logic              out_valid_r;
  tgt_t              res_tgt_r;
  logic [OFFS_W-1:0] res_offs_r;
  logic              res_inr_r;
  logic [BYTE_W-1:0] res_rd_r;
  logic              res_irq_r;
  logic              res_mirror_r;

  // Stage-1 combinational results
  tgt_t              tgt;
  logic [OFFS_W-1:0] offs;
  logic              inr;
  logic [BYTE_W-1:0] rd;
  logic [BYTE_W-1:0] ram_q;
  logic [12:0]       chr_a;
  logic [2:0]        chr_slot;
  logic [BYTE_W-1:0] chr_bank;
  logic [BYTE_W-1:0] chr_bank_no;
  logic [COUNT_W-1:0] prg_m2;
  logic [COUNT_W-1:0] prg_m1;
  logic [BYTE_W-1:0] prg_bank;
  logic [BYTE_W-1:0] cnt_dec;

  logic in_acc;
  logic adv;

  // Handshake
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_valid_r || adv);
  assign in_acc    = in_tvalid && in_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r <= PRG_COUNT_RESET;
      chr_count_r <= CHR_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_BANK_COUNT: prg_count_r <= cfg_data;
        CFG_CHR_BANK_COUNT: chr_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing sweep over the work RAM after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + RAM_AW'(1);
      if (clr_addr_r == {RAM_AW{1'b1}}) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Work RAM write port: sweep or item write
  assign ram_we    = clr_busy_r || (adv && item_ram_we);
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_addr_r[RAM_AW-1:0];
  assign ram_wdata = clr_busy_r ? '0 : s1_data_r;

  always_ff @(posedge clk) begin
    if (ram_we) begin
      work_ram[ram_waddr] <= ram_wdata;
    end
    if (in_acc) begin
      ram_rd_r <= work_ram[in_tdata[RAM_AW-1:0]];
    end
  end

  // Forward a write that lands in the same cycle as the read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_hit_r  <= ram_we && (ram_waddr == in_tdata[RAM_AW-1:0]);
      fwd_data_r <= ram_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= op_t'(in_tuser);
      s1_addr_r <= in_tdata[ADDR_W-1:0];
      s1_data_r <= in_tdata[ADDR_W+BYTE_W-1:ADDR_W];
    end
  end

  // Translate and update state for the item in the input register
  always_comb begin
    tgt               = TGT_NONE;
    offs              = '0;
    inr               = 1'b0;
    rd                = '0;
    item_ram_we       = 1'b0;
    bank_we           = 1'b0;
    bank_index_nxt    = bank_index_r;
    prg_swap_nxt      = prg_swap_r;
    chr_invert_nxt    = chr_invert_r;
    ram_enabled_nxt   = ram_enabled_r;
    ram_protected_nxt = ram_protected_r;
    mirror_vert_nxt   = mirror_vert_r;
    irq_latch_nxt     = irq_latch_r;
    irq_count_nxt     = irq_count_r;
    irq_reload_nxt    = irq_reload_r;
    irq_enable_nxt    = irq_enable_r;
    irq_flag_nxt      = irq_flag_r;

    ram_q = fwd_hit_r ? fwd_data_r : ram_rd_r;

    // Character banks: two 2 KB halves or four 1 KB quarters
    chr_a = s1_addr_r[12:0] ^ {chr_invert_r, 12'h000};
    if (!chr_a[12]) begin
      chr_slot    = {2'b00, chr_a[11]};
      chr_bank    = bank_table_r[chr_slot];
      chr_bank_no = {chr_bank[7:1], chr_a[10]};
    end else begin
      chr_slot    = SLOT_CHR_1K + {1'b0, chr_a[11:10]};
      chr_bank    = bank_table_r[chr_slot];
      chr_bank_no = chr_bank;
    end

    // Program windows
    prg_m2 = prg_count_r - 9'd2;
    prg_m1 = prg_count_r - 9'd1;
    case (s1_addr_r[14:13])
      WIN_0:   prg_bank = prg_swap_r ? prg_m2[7:0] : bank_table_r[SLOT_PRG_A];
      WIN_1:   prg_bank = bank_table_r[SLOT_PRG_B];
      WIN_2:   prg_bank = prg_swap_r ? bank_table_r[SLOT_PRG_A] : prg_m2[7:0];
      WIN_3:   prg_bank = prg_m1[7:0];
      default: prg_bank = prg_m1[7:0];
    endcase

    cnt_dec = irq_count_r - 8'd1;

    case (s1_op_r)
      OP_READ: begin
        if (s1_addr_r[15:13] == REGION_CHR) begin
          tgt  = TGT_CHR;
          offs = {3'b000, chr_bank_no, chr_a[9:0]};
          inr  = {1'b0, chr_bank_no} < chr_count_r;
        end else if (s1_addr_r[15:13] == REGION_RAM) begin
          tgt = TGT_RAM;
          rd  = ram_enabled_r ? ram_q : '0;
        end else if (s1_addr_r[15]) begin
          tgt  = TGT_PRG;
          offs = {prg_bank, s1_addr_r[12:0]};
          inr  = {1'b0, prg_bank} < prg_count_r;
        end
      end
      OP_WRITE: begin
        if (s1_addr_r[15:13] == REGION_RAM) begin
          item_ram_we = ram_enabled_r && !ram_protected_r;
        end else if (s1_addr_r[15]) begin
          case (s1_addr_r[14:13])
            GRP_BANK: begin
              if (s1_addr_r[0]) begin
                bank_we = 1'b1;
              end else begin
                bank_index_nxt = s1_data_r[2:0];
                prg_swap_nxt   = s1_data_r[6];
                chr_invert_nxt = s1_data_r[7];
              end
            end
            GRP_MIRROR: begin
              if (s1_addr_r[0]) begin
                ram_protected_nxt = s1_data_r[6];
                ram_enabled_nxt   = s1_data_r[7];
              end else begin
                mirror_vert_nxt = !s1_data_r[0];
              end
            end
            GRP_LATCH: begin
              if (s1_addr_r[0]) begin
                irq_reload_nxt = 1'b1;
              end else begin
                irq_latch_nxt = s1_data_r;
              end
            end
            GRP_IRQ_EN: begin
              if (s1_addr_r[0]) begin
                irq_enable_nxt = 1'b1;
              end else begin
                irq_enable_nxt = 1'b0;
                irq_flag_nxt   = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        // Reload on zero or pending reload, else count down
        if (irq_count_r == '0 || irq_reload_r) begin
          irq_count_nxt  = irq_latch_r;
          irq_reload_nxt = 1'b0;
        end else begin
          irq_count_nxt = cnt_dec;
        end
        if (irq_count_nxt == '0 && irq_enable_r) begin
          irq_flag_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Mapper state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_index_r    <= '0;
      prg_swap_r      <= 1'b0;
      chr_invert_r    <= 1'b0;
      ram_enabled_r   <= 1'b1;
      ram_protected_r <= 1'b0;
      mirror_vert_r   <= 1'b0;
      irq_latch_r     <= '0;
      irq_count_r     <= '0;
      irq_reload_r    <= 1'b0;
      irq_enable_r    <= 1'b0;
      irq_flag_r      <= 1'b0;
    end else if (adv) begin
      bank_index_r    <= bank_index_nxt;
      prg_swap_r      <= prg_swap_nxt;
      chr_invert_r    <= chr_invert_nxt;
      ram_enabled_r   <= ram_enabled_nxt;
      ram_protected_r <= ram_protected_nxt;
      mirror_vert_r   <= mirror_vert_nxt;
      irq_latch_r     <= irq_latch_nxt;
      irq_count_r     <= irq_count_nxt;
      irq_reload_r    <= irq_reload_nxt;
      irq_enable_r    <= irq_enable_nxt;
      irq_flag_r      <= irq_flag_nxt;
    end
  end

  // Bank table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        bank_table_r[i] <= '0;
      end
    end else if (adv && bank_we) begin
      bank_table_r[bank_index_r] <= s1_data_r;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_tgt_r    <= tgt;
      res_offs_r   <= offs;
      res_inr_r    <= inr;
      res_rd_r     <= rd;
      res_irq_r    <= irq_flag_nxt;
      res_mirror_r <= mirror_vert_nxt;
    end
  end

  // Drive the result stream
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_tgt_r;
  assign out_tdata  = {res_mirror_r, res_irq_r, res_rd_r, res_inr_r, res_offs_r};

endmodule
`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the cartridge bank mapper with scanline IRQ counter.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbmi_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 300;

  // One expected result transaction
  typedef struct packed {
    tgt_t              target;
    logic [OFFS_W-1:0] rom_offset;
    logic              in_range;
    logic [BYTE_W-1:0] read_data;
    logic              irq_pending;
    logic              mirror_vertical;
  } mapper_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [TGT_W-1:0]       out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [COUNT_W-1:0]     cfg_data = '0;

  // Mapper state as the testbench tracks it
  logic [COUNT_W-1:0] prg_count_q;
  logic [COUNT_W-1:0] chr_count_q;
  logic [2:0]         m_bank_sel;
  logic               m_prg_swap;
  logic               m_chr_invert;
  logic [7:0]         m_banks [8];
  logic               m_ram_en;
  logic               m_ram_prot;
  logic               m_mirror_v;
  logic [7:0]         m_latch;
  logic [7:0]         m_irq_count;
  logic               m_reload;
  logic               m_irq_en;
  logic               m_irq_flag;
  logic [7:0]         m_wram [WORK_RAM_DEPTH];

  mapper_result_t mapper_results_due [$];
  int             fail_count = 0;
  int             quiet_cycles = 0;
  bit             tx_idle_on = 1'b1;
  bit             rx_idle_on = 1'b1;
  int             hold_req = 0;
  int             hold_left = 0;
  int             stall_left = 0;
  mapper_result_t got_result;
  mapper_result_t want_result;

  cartridge_bank_mapper_irq_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom);
  endfunction

  // Address of a mapper register: upper half, group in bits 14:13, parity in bit 0
  function automatic logic [15:0] reg_addr(input logic [1:0] grp, input logic odd);
    return {1'b1, grp, 12'($urandom_range(0, 4095)), odd};
  endfunction

  // Work RAM offset, half the time in a small window so that reads hit earlier writes
  function automatic logic [12:0] ram_offset();
    if ($urandom_range(0, 1) == 0) begin
      return 13'($urandom_range(0, 15));
    end
    return 13'($urandom);
  endfunction

  // Restore power-up state of the tracked mapper
  task automatic reset_model();
    prg_count_q  = PRG_COUNT_RESET;
    chr_count_q  = CHR_COUNT_RESET;
    m_bank_sel   = '0;
    m_prg_swap   = 1'b0;
    m_chr_invert = 1'b0;
    m_ram_en     = 1'b1;
    m_ram_prot   = 1'b0;
    m_mirror_v   = 1'b0;
    m_latch      = '0;
    m_irq_count  = '0;
    m_reload     = 1'b0;
    m_irq_en     = 1'b0;
    m_irq_flag   = 1'b0;
    for (int i = 0; i < 8; i++) m_banks[i] = '0;
    for (int i = 0; i < WORK_RAM_DEPTH; i++) m_wram[i] = '0;
  endtask

  // Apply one accepted transaction to the tracked state and queue its result
  task automatic predict_mapper_access(input logic [OP_W-1:0] op,
                                       input logic [15:0] addr,
                                       input logic [7:0] wdata);
    mapper_result_t r;
    logic [12:0]    ca;
    logic [7:0]     bank;
    logic [8:0]     wrap;
    logic [7:0]     second_last;
    logic [7:0]     last_bank;
    r = '0;
    case (op)
      OP_READ: begin
        if (addr[15:13] == REGION_CHR) begin
          // Character space: invert swaps the 2 KB and 1 KB halves
          ca = addr[12:0];
          if (m_chr_invert) ca[12] = ~ca[12];
          if (!ca[12]) begin
            bank = m_banks[{2'b00, ca[11]}];
            r.rom_offset = {3'b000, bank[7:1], ca[10:0]};
          end else begin
            bank = m_banks[SLOT_CHR_1K + {1'b0, ca[11:10]}];
            r.rom_offset = {3'b000, bank, ca[9:0]};
          end
          r.target   = TGT_CHR;
          r.in_range = r.rom_offset[20:10] < {2'b00, chr_count_q};
        end else if (addr[15:13] == REGION_RAM) begin
          r.target = TGT_RAM;
          if (m_ram_en) r.read_data = m_wram[addr[12:0]];
        end else if (addr[15]) begin
          // Program windows; fixed banks wrap modulo 256
          wrap = prg_count_q - 9'd2;
          second_last = wrap[7:0];
          wrap = prg_count_q - 9'd1;
          last_bank = wrap[7:0];
          case (addr[14:13])
            WIN_0: bank = m_prg_swap ? second_last : m_banks[SLOT_PRG_A];
            WIN_1: bank = m_banks[SLOT_PRG_B];
            WIN_2: bank = m_prg_swap ? m_banks[SLOT_PRG_A] : second_last;
            default: bank = last_bank;
          endcase
          r.target     = TGT_PRG;
          r.rom_offset = {bank, addr[12:0]};
          r.in_range   = {1'b0, bank} < prg_count_q;
        end
      end
      OP_WRITE: begin
        if (addr[15:13] == REGION_RAM) begin
          if (m_ram_en && !m_ram_prot) m_wram[addr[12:0]] = wdata;
        end else if (addr[15]) begin
          case (addr[14:13])
            GRP_BANK: begin
              if (addr[0]) begin
                m_banks[m_bank_sel] = wdata;
              end else begin
                m_bank_sel   = wdata[2:0];
                m_prg_swap   = wdata[6];
                m_chr_invert = wdata[7];
              end
            end
            GRP_MIRROR: begin
              if (addr[0]) begin
                m_ram_prot = wdata[6];
                m_ram_en   = wdata[7];
              end else begin
                m_mirror_v = ~wdata[0];
              end
            end
            GRP_LATCH: begin
              if (addr[0]) m_reload = 1'b1;
              else m_latch = wdata;
            end
            default: begin
              if (addr[0]) begin
                m_irq_en = 1'b1;
              end else begin
                m_irq_en   = 1'b0;
                m_irq_flag = 1'b0;
              end
            end
          endcase
        end
      end
      OP_TICK: begin
        // Reload on zero or on request, else count down
        if (m_irq_count == 8'd0 || m_reload) begin
          m_irq_count = m_latch;
          m_reload    = 1'b0;
        end else begin
          m_irq_count = m_irq_count - 8'd1;
        end
        if (m_irq_count == 8'd0 && m_irq_en) m_irq_flag = 1'b1;
      end
      default: ;
    endcase
    r.irq_pending     = m_irq_flag;
    r.mirror_vertical = m_mirror_v;
    mapper_results_due.push_back(r);
  endtask

  // Predict on each input transaction, check each result transaction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_mapper_access(in_tuser, in_tdata[15:0], in_tdata[23:16]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_result.target          = tgt_t'(out_tuser);
      got_result.rom_offset      = out_tdata[20:0];
      got_result.in_range        = out_tdata[21];
      got_result.read_data       = out_tdata[29:22];
      got_result.irq_pending     = out_tdata[30];
      got_result.mirror_vertical = out_tdata[31];
      if (mapper_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("ERROR: result with no pending transaction");
      end else begin
        want_result = mapper_results_due.pop_front();
        if (got_result.target !== want_result.target ||
            got_result.rom_offset !== want_result.rom_offset ||
            got_result.in_range !== want_result.in_range ||
            got_result.read_data !== want_result.read_data ||
            got_result.irq_pending !== want_result.irq_pending ||
            got_result.mirror_vertical !== want_result.mirror_vertical) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: mismatch exp tgt=%0d off=%h rng=%0b rd=%h irq=%0b vm=%0b",
                     want_result.target, want_result.rom_offset, want_result.in_range,
                     want_result.read_data, want_result.irq_pending,
                     want_result.mirror_vertical);
            $display("                act tgt=%0d off=%h rng=%0b rd=%h irq=%0b vm=%0b",
                     got_result.target, got_result.rom_offset, got_result.in_range,
                     got_result.read_data, got_result.irq_pending,
                     got_result.mirror_vertical);
          end
        end
      end
    end
  end

  // Result receiver: long hold-off on request, random stall bursts otherwise
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one transaction, with an optional gap first; leave at a falling edge
  task automatic send_item(input op_t op, input logic [15:0] addr, input logic [7:0] wdata);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {wdata, addr};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Change idling modes away from the receiver's sampling edge
  task automatic set_idling(input bit tx, input bit rx);
    in_tvalid <= 1'b0;
    @(posedge clk);
    tx_idle_on = tx;
    rx_idle_on = rx;
    @(negedge clk);
  endtask

  // Stop offering and wait until every result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (mapper_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both bank counts; only called while the block is idle
  task automatic set_bank_counts(input logic [COUNT_W-1:0] prg, input logic [COUNT_W-1:0] chr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRG_BANK_COUNT;
    cfg_data  <= prg;
    @(negedge clk);
    cfg_index <= CFG_CHR_BANK_COUNT;
    cfg_data  <= chr;
    @(negedge clk);
    cfg_we <= 1'b0;
    prg_count_q = prg;
    chr_count_q = chr;
  endtask

  // One random transaction across all address regions and kinds
  task automatic send_random_item();
    int          pick;
    int          region;
    logic [15:0] addr;
    logic [1:0]  grp;
    logic [7:0]  wdata;
    pick  = $urandom_range(0, 99);
    wdata = rand_byte();
    if (pick < 35) begin
      region = $urandom_range(0, 9);
      if (region < 3) addr = {3'b000, 13'($urandom)};
      else if (region < 5) addr = {REGION_RAM, ram_offset()};
      else if (region < 8) addr = {1'b1, 15'($urandom)};
      else if (region == 8) addr = 16'($urandom_range(16'h2000, 16'h5FFF));
      else addr = rand_word();
      send_item(OP_READ, addr, wdata);
    end else if (pick < 55) begin
      grp = 2'($urandom_range(0, 3));
      addr = reg_addr(grp, $urandom_range(0, 1) == 1);
      // Favor short IRQ latch values so the flag fires
      if (grp == GRP_LATCH && !addr[0] && $urandom_range(0, 1) == 0) begin
        wdata = 8'($urandom_range(0, 7));
      end
      send_item(OP_WRITE, addr, wdata);
    end else if (pick < 65) begin
      send_item(OP_WRITE, {REGION_RAM, ram_offset()}, wdata);
    end else if (pick < 70) begin
      send_item(OP_WRITE, rand_word(), wdata);
    end else if (pick < 90) begin
      send_item(OP_TICK, rand_word(), wdata);
    end else if (pick < 95) begin
      send_item(OP_NONE, rand_word(), wdata);
    end else begin
      send_item(OP_READ, rand_word(), wdata);
    end
  endtask

  // Load the latch, request reload, enable, tick past zero, then acknowledge
  task automatic run_irq_countdown(input logic [7:0] lines);
    send_item(OP_WRITE, reg_addr(GRP_LATCH, 1'b0), lines);
    send_item(OP_WRITE, reg_addr(GRP_LATCH, 1'b1), rand_byte());
    send_item(OP_WRITE, reg_addr(GRP_IRQ_EN, 1'b1), rand_byte());
    repeat (lines + 32'd2) begin
      if ($urandom_range(0, 3) == 0) send_item(OP_READ, rand_word(), rand_byte());
      send_item(OP_TICK, rand_word(), rand_byte());
    end
    send_item(OP_WRITE, reg_addr(GRP_IRQ_EN, 1'b0), rand_byte());
  endtask

  // Directed: field extremes, every kind, and the special cases at reset counts
  task automatic test_directed_map();
    send_item(OP_READ,  16'h0000, 8'h00);  // no character banks: out of range
    send_item(OP_READ,  16'hFFFF, 8'hFF);  // fixed last program bank
    send_item(OP_WRITE, 16'h8000, 8'hC7);  // select slot 7, swap and invert
    send_item(OP_WRITE, 16'h8001, 8'hFF);
    send_item(OP_WRITE, 16'h8000, 8'h00);
    send_item(OP_WRITE, 16'h9FFF, 8'hFF);  // slot 0 through the top odd address
    send_item(OP_WRITE, 16'h8000, 8'h46);  // slot 6, swapped program windows
    send_item(OP_WRITE, 16'h8001, 8'h01);
    send_item(OP_READ,  16'h8000, 8'h00);
    send_item(OP_READ,  16'hC000, 8'h00);
    send_item(OP_READ,  16'hA000, 8'h00);  // bank past the count
    send_item(OP_READ,  16'h07FF, 8'h00);
    send_item(OP_READ,  16'h1FFF, 8'h00);
    send_item(OP_READ,  16'h3000, 8'h00);  // unmapped hole
    send_item(OP_WRITE, 16'h7FFF, 8'hFF);
    send_item(OP_READ,  16'h7FFF, 8'h00);
    send_item(OP_WRITE, 16'hA001, 8'h40);  // disable and protect work RAM
    send_item(OP_READ,  16'h7FFF, 8'h00);
    send_item(OP_WRITE, 16'h6000, 8'h5A);  // dropped while disabled
    send_item(OP_WRITE, 16'hA001, 8'h80);
    send_item(OP_READ,  16'h6000, 8'h00);
    send_item(OP_WRITE, 16'hA000, 8'h00);  // vertical mirroring
    send_item(OP_WRITE, 16'hC000, 8'h00);
    send_item(OP_WRITE, 16'hE001, 8'h00);
    send_item(OP_TICK,  16'h0000, 8'h00);  // zero latch fires at once
    send_item(OP_WRITE, 16'hE000, 8'h00);
    send_item(OP_NONE,  16'hFFFF, 8'hFF);  // unused kind
    send_item(OP_WRITE, 16'h1FFF, 8'hFF);  // character space write dropped
  endtask

  // Sweep bank counts through extremes and wrapping values
  task automatic test_bank_counts();
    logic [COUNT_W-1:0] prg_set [6];
    logic [COUNT_W-1:0] chr_set [6];
    prg_set = '{9'd2, 9'd256, 9'd0, 9'd1, 9'd511, 9'($urandom_range(2, 256))};
    chr_set = '{9'd0, 9'd256, 9'd1, 9'd511, 9'd255, 9'($urandom_range(0, 256))};
    for (int s = 0; s < 6; s++) begin
      wait_idle();
      set_bank_counts(prg_set[s], chr_set[s]);
      repeat (40) send_random_item();
    end
  endtask

  // Scanline counter sequences of several lengths
  task automatic test_irq_countdown();
    run_irq_countdown(8'd0);
    run_irq_countdown(8'd1);
    run_irq_countdown(8'd3);
    run_irq_countdown(8'd7);
    run_irq_countdown(8'd20);
  endtask

  // Hold the receiver off so the block fills and stalls its input
  task automatic test_backpressure();
    set_idling(1'b0, 1'b0);
    @(posedge clk);
    hold_req = HOLD_CYCLES;
    @(negedge clk);
    repeat (40) send_random_item();
  endtask

  // Random mix with countdown sequences; no idling near the end
  task automatic test_random_mix();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 120) begin
        set_idling(1'b0, 1'b0);
      end else if (i % 100 == 0 && i < RANDOM_ITEMS - 120) begin
        set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 39) == 0) run_irq_countdown(8'($urandom_range(0, 6)));
      else send_random_item();
    end
  endtask

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_map();
    test_bank_counts();
    test_irq_countdown();
    test_backpressure();
    test_random_mix();
    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
